/* rtl/core/pps_pkg.sv */
// Package for the preemptive priority scheduler: sizes, result kinds, entry types.
// No dependencies.
`default_nettype none
package pps_pkg;
    localparam int MaxProcs = 64;
    localparam int HeapAw   = $clog2(MaxProcs);
    localparam int CountW   = HeapAw + 1;
    localparam int IdW      = 6;

    localparam logic [2:0] KIND_ACCEPT = 3'd0;
    localparam logic [2:0] KIND_REJECT = 3'd1;
    localparam logic [2:0] KIND_IDLE   = 3'd2;
    localparam logic [2:0] KIND_RAN    = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;

    typedef struct packed {
        logic [IdW-1:0] id;
        logic [7:0]     prio;
        logic [15:0]    remain;
    } heap_entry_t;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] response;
        logic        responded;
    } proc_entry_t;
endpackage
`default_nettype wire

/* rtl/core/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler over a binary min-heap held in a synchronous RAM.
// Depends on pps_pkg.
//
// Usage:
//   s_axis: one item per handshake. tdata = {func, process_id, priority_level,
//   burst_length} from bit 0 upward. func 0 pushes a process, func 1 is a tick.
//   m_axis: one result item per input item, in order. tdata = kind, ran_id,
//   step_time, completion_time, waiting_time, response_time from bit 0 upward.
// Flow: one item at a time. A rejected arrival or an idle tick has its result
//   registered straight from idle. An accepted arrival is written to the end slot
//   and climbs past each larger parent, then settles. A tick reads the root and
//   the last entry, sifts down level by level, settles, reads the process table,
//   then either pushes the process back and climbs as an arrival does or gives
//   its done result. The heap RAM's single port with its registered read sets the
//   pace: each level reads, compares and writes back. The next item is accepted
//   the cycle after the result is taken.
// Reset: heap count and time clear; the heap and process RAMs are not cleared
//   since only written entries are ever read.
// Stall: a finished result sits in the output register; s_axis_tready stays low
//   until it is taken, then the next item is accepted.
`default_nettype none
module preemptive_priority_scheduler
    import pps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // func[0], process_id[6:1], priority_level[14:7], burst_length[30:15], zero pad
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // kind[2:0], ran_id[8:3], step_time[24:9], completion_time[40:25],
    // waiting_time[56:41], response_time[72:57], zero pad
    output logic [79:0]      m_axis_tdata
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_POP0  = 4'd1;  // root read issued
    localparam logic [3:0] ST_POP1  = 4'd2;  // last read issued
    localparam logic [3:0] ST_DNL   = 4'd3;  // left child read issued
    localparam logic [3:0] ST_DNR   = 4'd4;  // right child read issued
    localparam logic [3:0] ST_DNCMP = 4'd5;
    localparam logic [3:0] ST_PROC  = 4'd6;  // proc table read issued
    localparam logic [3:0] ST_UP    = 4'd7;  // parent read issued
    localparam logic [3:0] ST_UPCMP = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;
    localparam logic [3:0] ST_SINK  = 4'd10; // next sift-down level

    heap_entry_t heap_mem [MaxProcs];
    proc_entry_t proc_mem [64];
    heap_entry_t heap_rd;
    proc_entry_t proc_rd;

    logic               heap_we, proc_we;
    logic [HeapAw-1:0]  heap_addr;
    heap_entry_t        heap_wd;
    logic [IdW-1:0]     proc_addr;
    proc_entry_t        proc_wd;

    always_ff @(posedge clk)
    begin
        if (heap_we)
            heap_mem[heap_addr] <= heap_wd;
        heap_rd <= heap_mem[heap_addr];
    end

    always_ff @(posedge clk)
    begin
        if (proc_we)
            proc_mem[proc_addr] <= proc_wd;
        proc_rd <= proc_mem[proc_addr];
    end

    logic [3:0]        state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [15:0]       time_reg, time_next;
    heap_entry_t       cur_reg, cur_next;     // entry being sifted
    heap_entry_t       top_reg, top_next;     // popped entry
    heap_entry_t       best_reg, best_next;   // smallest of sifting entry and its children so far
    logic [HeapAw-1:0] pos_reg, pos_next;
    logic [HeapAw-1:0] bpos_reg, bpos_next;
    logic              bsel_reg, bsel_next;
    logic [79:0]       out_reg, out_next;
    logic              ov_reg, ov_next;

    logic        in_func;
    logic [5:0]  in_id;
    logic [7:0]  in_prio;
    logic [15:0] in_burst;
    assign in_func  = s_axis_tdata[0];
    assign in_id    = s_axis_tdata[6:1];
    assign in_prio  = s_axis_tdata[14:7];
    assign in_burst = s_axis_tdata[30:15];

    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    logic [CountW:0]   lidx, ridx;
    logic [HeapAw-1:0] parent;
    logic [15:0]       done_t, remain_dec;
    logic signed [18:0] wait_s;
    logic [15:0]       wait_c, resp_v;
    assign lidx   = (CountW+1)'({pos_reg, 1'b1});
    assign ridx   = {pos_reg, 1'b0} + (CountW+1)'(2);
    assign parent = HeapAw'((pos_reg - HeapAw'(1)) >> 1);
    assign done_t = (time_reg == 16'hFFFF) ? time_reg : time_reg + 16'd1;
    assign remain_dec = top_reg.remain - 16'd1;
    assign resp_v = proc_rd.responded ? proc_rd.response : time_reg - proc_rd.arrival;
    assign wait_s = $signed({3'b000, done_t}) - $signed({3'b000, proc_rd.arrival})
                  - $signed({3'b000, proc_rd.burst});
    assign wait_c = wait_s[18] ? 16'd0 : wait_s[15:0];

    function automatic logic [79:0] pack_out(logic [2:0] k, logic [5:0] id,
        logic [15:0] st, logic [15:0] ct, logic [15:0] wt, logic [15:0] rt);
        pack_out = {7'd0, rt, wt, ct, st, id, k};
    endfunction

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        time_next  = time_reg;
        cur_next   = cur_reg;
        top_next   = top_reg;
        best_next  = best_reg;
        pos_next   = pos_reg;
        bpos_next  = bpos_reg;
        bsel_next  = bsel_reg;
        out_next   = out_reg;
        ov_next    = ov_reg;
        heap_we    = 1'b0;
        heap_addr  = pos_reg;
        heap_wd    = cur_reg;
        proc_we    = 1'b0;
        proc_addr  = top_reg.id;
        proc_wd    = proc_rd;
        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (!in_func)
                    begin
                        if (count_reg == CountW'(MaxProcs) || in_burst == 16'd0)
                        begin
                            out_next = pack_out(KIND_REJECT, in_id, time_reg, 16'd0,
                                                16'd0, 16'd0);
                            ov_next  = 1'b1;
                        end
                        else
                        begin
                            proc_we   = 1'b1;
                            proc_addr = in_id;
                            proc_wd   = '{arrival: time_reg, burst: in_burst,
                                          response: 16'd0, responded: 1'b0};
                            cur_next  = '{id: in_id, prio: in_prio, remain: in_burst};
                            pos_next  = count_reg[HeapAw-1:0];
                            heap_we   = 1'b1;
                            heap_addr = count_reg[HeapAw-1:0];
                            heap_wd   = '{id: in_id, prio: in_prio, remain: in_burst};
                            count_next = count_reg + CountW'(1);
                            out_next  = pack_out(KIND_ACCEPT, in_id, time_reg, 16'd0,
                                                 16'd0, 16'd0);
                            pos_next  = count_reg[HeapAw-1:0];
                            state_next = (count_reg == '0) ? ST_OUT : ST_UP;
                            heap_addr = count_reg[HeapAw-1:0];
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_next = pack_out(KIND_IDLE, 6'd0, time_reg, 16'd0, 16'd0,
                                            16'd0);
                        ov_next  = 1'b1;
                        if (time_reg != 16'hFFFF)
                            time_next = time_reg + 16'd1;
                    end
                    else
                    begin
                        heap_addr  = '0;
                        state_next = ST_POP0;
                    end
                end
            end
            ST_POP0:
            begin
                top_next   = heap_rd;
                count_next = count_reg - CountW'(1);
                heap_addr  = HeapAw'(count_reg - CountW'(1));
                pos_next   = '0;
                state_next = ST_POP1;
            end
            ST_POP1:
            begin
                cur_next  = heap_rd;
                if (count_reg == '0)
                begin
                    proc_addr  = top_reg.id;
                    state_next = ST_PROC;
                end
                else if (lidx < (CountW+1)'(count_reg))
                begin
                    heap_addr  = lidx[HeapAw-1:0];
                    state_next = ST_DNL;
                end
                else
                begin
                    heap_we    = 1'b1;
                    heap_addr  = '0;
                    heap_wd    = heap_rd;
                    proc_addr  = top_reg.id;
                    state_next = ST_PROC;
                end
            end
            ST_SINK:
            begin
                if (lidx < (CountW+1)'(count_reg))
                begin
                    heap_addr  = lidx[HeapAw-1:0];
                    state_next = ST_DNL;
                end
                else
                begin
                    // no children left: settle the sinking entry here
                    heap_we    = 1'b1;
                    heap_addr  = pos_reg;
                    heap_wd    = cur_reg;
                    proc_addr  = top_reg.id;
                    state_next = ST_PROC;
                end
            end
            ST_DNL:
            begin
                if (heap_rd.prio < cur_reg.prio)
                begin
                    best_next = heap_rd;
                    bpos_next = lidx[HeapAw-1:0];
                    bsel_next = 1'b1;
                end
                else
                begin
                    best_next = cur_reg;
                    bsel_next = 1'b0;
                end
                if (ridx < (CountW+1)'(count_reg))
                begin
                    heap_addr  = ridx[HeapAw-1:0];
                    state_next = ST_DNR;
                end
                else
                    state_next = ST_DNCMP;
            end
            ST_DNR:
            begin
                if (heap_rd.prio < best_reg.prio)
                begin
                    best_next = heap_rd;
                    bpos_next = ridx[HeapAw-1:0];
                    bsel_next = 1'b1;
                end
                state_next = ST_DNCMP;
            end
            ST_DNCMP:
            begin
                heap_we   = 1'b1;
                heap_addr = pos_reg;
                if (bsel_reg)
                begin
                    // move the smaller child up, keep sinking
                    heap_wd  = best_reg;
                    pos_next = bpos_reg;
                    state_next = ST_SINK;
                    heap_we  = 1'b1;
                end
                else
                begin
                    heap_wd    = cur_reg;
                    proc_addr  = top_reg.id;
                    state_next = ST_PROC;
                end
            end
            ST_PROC:
            begin
                if (!proc_rd.responded)
                begin
                    proc_we = 1'b1;
                    proc_wd = '{arrival: proc_rd.arrival, burst: proc_rd.burst,
                                response: resp_v, responded: 1'b1};
                end
                if (time_reg != 16'hFFFF)
                    time_next = time_reg + 16'd1;
                if (remain_dec != 16'd0)
                begin
                    out_next = pack_out(KIND_RAN, top_reg.id, time_reg, 16'd0, 16'd0,
                                        16'd0);
                    cur_next  = '{id: top_reg.id, prio: top_reg.prio, remain: remain_dec};
                    heap_we   = 1'b1;
                    heap_addr = count_reg[HeapAw-1:0];
                    heap_wd   = '{id: top_reg.id, prio: top_reg.prio, remain: remain_dec};
                    pos_next  = count_reg[HeapAw-1:0];
                    count_next = count_reg + CountW'(1);
                    state_next = (count_reg == '0) ? ST_OUT : ST_UP;
                end
                else
                begin
                    out_next = pack_out(KIND_DONE, top_reg.id, time_reg, done_t, wait_c,
                                        resp_v);
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_UP:
            begin
                heap_addr  = parent;
                state_next = ST_UPCMP;
            end
            ST_UPCMP:
            begin
                if (heap_rd.prio > cur_reg.prio)
                begin
                    // swap: parent down, climb
                    heap_we   = 1'b1;
                    heap_addr = pos_reg;
                    heap_wd   = heap_rd;
                    pos_next  = parent;
                    state_next = (parent == '0) ? ST_OUT : ST_UP;
                end
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // settle the sifting entry at its final slot
                heap_we    = 1'b1;
                heap_addr  = pos_reg;
                heap_wd    = cur_reg;
                ov_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            time_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            time_reg  <= time_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        top_reg  <= top_next;
        best_reg <= best_next;
        pos_reg  <= pos_next;
        bpos_reg <= bpos_next;
        bsel_reg <= bsel_next;
        out_reg  <= out_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(MaxProcs))
        else $error("heap count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !m_axis_tready) |=> ($stable(out_reg) && ov_reg))
        else $error("result changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (state_reg == ST_IDLE))
        else $error("result pending while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (time_reg == 16'hFFFF) |=> (time_reg == 16'hFFFF))
        else $error("time wrapped");
endmodule
`default_nettype wire
